// ===== rtl/core/gb3_pkg.sv =====
// Shared constants and register codes for the 3x3 binomial blur block.
package gb3_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF    = 2048;
   localparam int MAX_HEIGHT_DEF   = 4096;
   localparam int CHANNEL_BITS_DEF = 8;

   // Fixed field widths of the result position
   localparam int COL_BITS = 11;
   localparam int ROW_BITS = 12;

   // Configuration port
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 13;
   localparam int IMG_WIDTH_BITS  = 12;
   localparam int IMG_HEIGHT_BITS = 13;
   localparam int BORDER_BITS     = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMG_WIDTH    = 2'd0,
      REG_IMG_HEIGHT   = 2'd1,
      REG_BORDER_VALUE = 2'd2
   } csr_reg_type;

   localparam int IMG_WIDTH_RESET  = 640;
   localparam int IMG_HEIGHT_RESET = 480;
   localparam int BORDER_RESET     = 255;

   // Input item kinds (carried on req_tuser)
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // Result queue depth
   localparam int OUT_QUEUE_DEPTH = 4;

endpackage

// ===== rtl/core/gaussian_blur_3x3.sv =====
// Streaming 3x3 binomial blur with a dual line store and a 3x3 window.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  req     | in        | req_tvalid/tready   | tdata: red, green, blue; tuser: item kind
//  rsp     | out       | rsp_tvalid/tready   | tdata: red, green, blue, col, row; tlast
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data (always ready)
//
// One item per cycle sustained unless the queue backs up: each item makes one
// read and one write of the line store (one read port, one write port), and a
// 4-entry result queue keeps req_tready independent of rsp_tready. A result
// is registered through the window and sum stages before it enters the queue.
// Reset is synchronous; line store contents are left as they are. req_tready
// drops only while the queue plus items in flight would fill it.
module gaussian_blur_3x3 #(
   parameter int MAX_WIDTH    = gb3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = gb3_pkg::MAX_HEIGHT_DEF,
   parameter int CHANNEL_BITS = gb3_pkg::CHANNEL_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // in: red, green, blue, zero pad
   input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]     req_tdata,
   // in: item kind (0 pixel, 1 drain)
   input  logic                                    req_tuser,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // out: red, green, blue, col, row, zero pad
   output logic [((3*CHANNEL_BITS+gb3_pkg::COL_BITS+gb3_pkg::ROW_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                                    rsp_tlast,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [gb3_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [gb3_pkg::CSR_DATA_BITS-1:0]       csr_data
);
   import gb3_pkg::*;

   localparam int CB     = CHANNEL_BITS;
   localparam int PW     = 3 * CB;                      // one pixel
   localparam int CW     = $clog2(MAX_WIDTH);           // column index
   localparam int WW     = CW + 1;                      // width value
   localparam int RW     = $clog2(MAX_HEIGHT) + 1;      // row counter and height
   localparam int SW     = CB + 4;                      // weighted sum
   localparam int RSP_DW = ((PW + COL_BITS + ROW_BITS + 7) / 8) * 8;
   localparam int QD     = OUT_QUEUE_DEPTH;
   localparam int QCW    = $clog2(QD + 1);
   localparam int W_RST  = (IMG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMG_WIDTH_RESET;
   localparam int H_RST  = (IMG_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : IMG_HEIGHT_RESET;

   typedef struct packed {
      logic                emit;
      logic                last;
      logic                top;
      logic                bot;
      logic                left;
      logic                right;
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
   } out_meta_type;

   typedef struct packed {
      logic                last;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic [PW-1:0]       pix;
   } rsp_item_type;

   // Configuration, stored already clamped
   logic [WW-1:0] eff_w_ff, eff_w_in;
   logic [RW-1:0] eff_h_ff, eff_h_in;
   logic [BORDER_BITS-1:0] border_ff, border_in;
   logic [CB-1:0] border_ch;

   // Input position
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;

   // Line store: upper line in the low half, middle line in the high half
   logic [2*PW-1:0] line_mem [MAX_WIDTH];
   logic [2*PW-1:0] rd_word_ff;
   logic [2*PW-1:0] fwd_word_ff;
   logic [2*PW-1:0] eff_rd;
   logic [2*PW-1:0] wr_word;

   // Stage 1: line store data arrives
   logic            s1_valid_ff;
   logic            s1_fwd_ff;
   logic [CW-1:0]   s1_idx_ff;
   logic [PW-1:0]   s1_fresh_ff;
   out_meta_type    s1_meta_ff;

   // Stage 2: window holds this item's neighborhood
   logic            s2_valid_ff;
   out_meta_type    s2_meta_ff;
   logic [PW-1:0]   win_ff [3][3];   // [left..right][top..bottom]
   rsp_item_type    s2_item;

   // Result queue, head at entry 0
   rsp_item_type    q_ff [QD];
   rsp_item_type    q_in [QD];
   logic [QCW-1:0]  q_count_ff, q_count_in;
   logic [QCW-1:0]  wr_slot;
   logic [QCW:0]    occupancy;
   logic            push, pop;

   // Stage 0 decode
   logic            draining, s0_go, emit, at_col0, last;
   logic [CW-1:0]   ocol;
   logic [RW-1:0]   orow;
   logic [WW-1:0]   col_plus;
   logic [PW-1:0]   fresh;
   out_meta_type    s0_meta;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;
   assign border_ch = CB'(border_ff);

   always_comb begin
      eff_w_in  = eff_w_ff;
      eff_h_in  = eff_h_ff;
      border_in = border_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_IMG_WIDTH: begin
               if (csr_data[IMG_WIDTH_BITS-1:0] < IMG_WIDTH_BITS'(2))
                  eff_w_in = WW'(2);
               else if (32'(csr_data[IMG_WIDTH_BITS-1:0]) > MAX_WIDTH)
                  eff_w_in = WW'(MAX_WIDTH);
               else
                  eff_w_in = WW'(csr_data[IMG_WIDTH_BITS-1:0]);
            end
            REG_IMG_HEIGHT: begin
               if (csr_data[IMG_HEIGHT_BITS-1:0] < IMG_HEIGHT_BITS'(2))
                  eff_h_in = RW'(2);
               else if (32'(csr_data[IMG_HEIGHT_BITS-1:0]) > MAX_HEIGHT)
                  eff_h_in = RW'(MAX_HEIGHT);
               else
                  eff_h_in = RW'(csr_data[IMG_HEIGHT_BITS-1:0]);
            end
            REG_BORDER_VALUE: begin
               border_in = csr_data[BORDER_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff  <= WW'(W_RST);
         eff_h_ff  <= RW'(H_RST);
         border_ff <= BORDER_BITS'(BORDER_RESET);
      end else begin
         eff_w_ff  <= eff_w_in;
         eff_h_ff  <= eff_h_in;
         border_ff <= border_in;
      end
   end

   // ---------------- stage 0: accept and position ----------------
   assign occupancy  = (QCW+1)'(q_count_ff) + (QCW+1)'(s1_valid_ff & s1_meta_ff.emit)
                     + (QCW+1)'(s2_valid_ff);
   assign req_tready = occupancy < (QCW+1)'(QD);

   assign draining = in_row_ff >= eff_h_ff;
   assign s0_go    = req_tvalid && req_tready && (draining || req_tuser == REQ_PIXEL);
   assign at_col0  = in_col_ff == '0;
   assign emit     = (in_row_ff >= RW'(2)) || (in_row_ff == RW'(1) && !at_col0);
   assign ocol     = at_col0 ? CW'(eff_w_ff - WW'(1)) : in_col_ff - CW'(1);
   assign orow     = at_col0 ? in_row_ff - RW'(2) : in_row_ff - RW'(1);
   assign last     = emit && (orow >= eff_h_ff - RW'(1))
                          && (WW'(ocol) >= eff_w_ff - WW'(1));
   assign col_plus = WW'(in_col_ff) + WW'(1);
   assign fresh    = draining ? {3{border_ch}} : req_tdata[PW-1:0];

   always_comb begin
      s0_meta.emit  = emit;
      s0_meta.last  = last;
      s0_meta.top   = orow == '0;
      s0_meta.bot   = orow >= eff_h_ff - RW'(1);
      s0_meta.left  = ocol == '0;
      s0_meta.right = WW'(ocol) >= eff_w_ff - WW'(1);
      s0_meta.col   = COL_BITS'(ocol);
      s0_meta.row   = ROW_BITS'(orow);
   end

   // Advance the input slot; the frame's last result restarts it
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (s0_go) begin
         if (last) begin
            in_col_in = '0;
            in_row_in = '0;
         end else if (col_plus >= eff_w_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = CW'(col_plus);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         s1_valid_ff <= s0_go;
         s2_valid_ff <= s1_valid_ff && s1_meta_ff.emit;
      end
   end

   // Stage 1 payload; forward when the previous item hit the same column
   always_ff @(posedge clock) begin
      if (s0_go) begin
         s1_fwd_ff   <= s1_valid_ff && (s1_idx_ff == in_col_ff);
         fwd_word_ff <= wr_word;
         s1_idx_ff   <= in_col_ff;
         s1_fresh_ff <= fresh;
         s1_meta_ff  <= s0_meta;
      end
   end

   // ---------------- line store ----------------
   always_ff @(posedge clock) begin
      if (s1_valid_ff)
         line_mem[s1_idx_ff] <= wr_word;
      if (s0_go)
         rd_word_ff <= line_mem[in_col_ff];
   end

   // ---------------- stage 1: window update ----------------
   assign eff_rd  = s1_fwd_ff ? fwd_word_ff : rd_word_ff;
   assign wr_word = {s1_fresh_ff, eff_rd[2*PW-1:PW]};

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int y = 0; y < 3; y++) begin
            win_ff[0][y] <= win_ff[1][y];
            win_ff[1][y] <= win_ff[2][y];
         end
         win_ff[2][0] <= eff_rd[PW-1:0];
         win_ff[2][1] <= eff_rd[2*PW-1:PW];
         win_ff[2][2] <= s1_fresh_ff;
         s2_meta_ff   <= s1_meta_ff;
      end
   end

   // ---------------- stage 2: weighted sum ----------------
   always_comb begin
      logic [SW-1:0] sum;
      logic [CB-1:0] v;
      logic          outside;
      for (int c = 0; c < 3; c++) begin
         sum = '0;
         for (int x = 0; x < 3; x++) begin
            for (int y = 0; y < 3; y++) begin
               outside = (y == 0 && s2_meta_ff.top) || (y == 2 && s2_meta_ff.bot) ||
                         (x == 0 && s2_meta_ff.left) || (x == 2 && s2_meta_ff.right);
               v = outside ? border_ch : win_ff[x][y][c*CB +: CB];
               sum = sum + (SW'(v) << ((x == 1 ? 1 : 0) + (y == 1 ? 1 : 0)));
            end
         end
         s2_item.pix[c*CB +: CB] = sum[SW-1:4];
      end
      s2_item.last = s2_meta_ff.last;
      s2_item.row  = s2_meta_ff.row;
      s2_item.col  = s2_meta_ff.col;
   end

   // ---------------- result queue ----------------
   assign push    = s2_valid_ff;
   assign pop     = (q_count_ff != '0) && rsp_tready;
   assign wr_slot = q_count_ff - QCW'(pop);

   always_comb begin
      for (int i = 0; i < QD; i++) begin
         if (pop && i < QD - 1)
            q_in[i] = q_ff[(i < QD - 1) ? i + 1 : i];
         else
            q_in[i] = q_ff[i];
         if (push && wr_slot == QCW'(i))
            q_in[i] = s2_item;
      end
      q_count_in = q_count_ff + QCW'(push) - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset)
         q_count_ff <= '0;
      else
         q_count_ff <= q_count_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QD; i++)
         q_ff[i] <= q_in[i];
   end

   assign rsp_tvalid = q_count_ff != '0;
   assign rsp_tlast  = q_ff[0].last;
   assign rsp_tdata  = RSP_DW'({q_ff[0].row, q_ff[0].col, q_ff[0].pix});

endmodule
